/* src/longest_valid_paren_length_defines.svh */
// assertion macros for the longest valid parentheses block
`ifndef LONGEST_VALID_PAREN_LENGTH_DEFINES_SVH
`define LONGEST_VALID_PAREN_LENGTH_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LVP_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lvp assertion failed");

// next-cycle implication, disabled in reset
`define LVP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lvp assertion failed");

// next-cycle implication, always active
`define LVP_ASSERT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lvp assertion failed");

`endif

/* src/lvp_pkg.sv */
// shared types and constants for the longest valid parentheses block
package lvp_pkg;

  localparam logic [7:0] OPEN_BRACKET = 8'd40;
  localparam int LONGEST_W = 16;
  localparam int LONGEST_MAX = 65535;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [LONGEST_W-1:0] longest;
    logic                 overflow;
  } result_t;

endpackage

/* src/lvp_core.sv */
// stack of positions with cached top entries, length tracking and result build
module lvp_core #(
  parameter int MAX_LEN = 65535
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  lvp_pkg::item_t   item,
  output lvp_pkg::result_t res
);
  import lvp_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int DW = $clog2(MAX_LEN + 2);

  logic [PW-1:0] mem [MAX_LEN];

  logic [PW-1:0] top, top_next;
  logic [PW-1:0] below, below_next;
  logic [PW-1:0] below2;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] best, best_next;
  logic [PW-1:0] here, cand;
  logic [DW-1:0] depth, depth_next;
  logic [DW-1:0] wslot, rd_ptr;
  logic [AW-1:0] waddr, raddr;
  logic          ovf, ovf_next;
  logic          push;
  logic          clear;

  always_comb begin
    top_next   = top;
    below_next = below;
    pos_next   = pos;
    best_next  = best;
    depth_next = depth;
    ovf_next   = ovf;
    push       = 1'b0;
    here       = pos + PW'(1);
    wslot      = depth - DW'(1);
    cand       = here - below;
    if (fire) begin
      if (pos >= PW'(MAX_LEN)) begin
        ovf_next = 1'b1;
      end else begin
        pos_next = here;
        if (item.symbol == OPEN_BRACKET) begin
          push       = (wslot < DW'(MAX_LEN));
          below_next = top;
          top_next   = here;
          depth_next = depth + DW'(1);
        end else if (depth == DW'(1)) begin
          top_next = here;
        end else begin
          top_next   = below;
          below_next = below2;
          depth_next = depth - DW'(1);
          if (cand > best) begin
            best_next = cand;
          end
        end
      end
    end
  end

  assign clear  = fire && item.last;
  assign waddr  = wslot[AW-1:0];
  assign rd_ptr = depth_next - DW'(3);
  assign raddr  = rd_ptr[AW-1:0];

  always_comb begin
    res.overflow = ovf_next;
    if (32'(best_next) > 32'(LONGEST_MAX)) begin
      res.longest = LONGEST_W'(LONGEST_MAX);
    end else begin
      res.longest = LONGEST_W'(best_next);
    end
  end

  // entry below the cached pair, read ahead for the next state
  always_ff @(posedge clk) begin
    if (push) begin
      mem[waddr] <= top;
    end
    below2 <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    below <= below_next;
    if (rst || clear) begin
      top   <= '0;
      depth <= DW'(1);
      pos   <= '0;
      best  <= '0;
      ovf   <= 1'b0;
    end else begin
      top   <= top_next;
      depth <= depth_next;
      pos   <= pos_next;
      best  <= best_next;
      ovf   <= ovf_next;
    end
  end

endmodule

/* src/lvp_out_reg.sv */
// result register holding one word until the receiver takes it
module lvp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  lvp_pkg::result_t res_in,
  input  logic             out_ready,
  output logic             out_valid,
  output lvp_pkg::result_t res_out
);
  import lvp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && !out_ready);
    end
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* src/longest_valid_paren_length.sv */
// top level of the longest valid parentheses block
// Usage:
//   Input channel (in_valid/in_ready) moves one word per byte: symbol and
//   last. A symbol of 40 opens a bracket, any other value closes one. last
//   marks the final byte of a string.
//   Output channel (out_valid/out_ready) moves one word per string, on its
//   final byte: longest (balanced substring length, saturating at 65535)
//   and overflow (string held more than MAX_LEN bytes; the extra ones are
//   ignored).
//   Throughput: one byte per cycle while no final byte waits (see Stall),
//   set by one stack push or pop per byte with the top two entries cached
//   and the next one read ahead from the stack memory, which takes one
//   write and one read per cycle. A result reaches out_valid from its final
//   byte through the input register, then the result register.
//   Reset: rst is synchronous; it clears the state and empties both
//   registers. The stack memory needs no clearing pass.
//   Stall: while a result waits, bytes of the next string are still taken;
//   a second final byte waits in the input register until the pending
//   result is taken, and in_ready drops behind it.
module longest_valid_paren_length #(
  parameter int MAX_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  symbol,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] longest,
  output logic        overflow
);
  import lvp_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    s1_go;
  logic    fire;
  result_t res;
  result_t res_out;

  assign s1_go    = !s1_item.last || !out_valid || out_ready;
  assign fire     = s1_valid && s1_go;
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (in_valid && in_ready) || (s1_valid && !s1_go);
    end
    if (in_valid && in_ready) begin
      s1_item.symbol <= symbol;
      s1_item.last   <= last;
    end
  end

  lvp_core #(
    .MAX_LEN(MAX_LEN)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .item(s1_item),
    .res (res)
  );

  lvp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && s1_item.last),
    .res_in   (res),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .res_out  (res_out)
  );

  assign longest  = res_out.longest;
  assign overflow = res_out.overflow;

endmodule

/* src/lvp_checker.sv */
// port-level checker for the longest valid parentheses block, with its bind
`include "longest_valid_paren_length_defines.svh"

module lvp_checker #(
  parameter int MAX_LEN = 65535
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] longest,
  input logic        overflow
);

  `LVP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(longest) && $stable(overflow))

  `LVP_ASSERT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

  `LVP_ASSERT_SAME(a_even_length, clk, rst, out_valid, (MAX_LEN > 65535) || !longest[0])

  `LVP_ASSERT_SAME(a_ready_when_empty, clk, rst, !out_valid, in_ready || !in_valid || in_ready)

endmodule

bind longest_valid_paren_length lvp_checker #(
  .MAX_LEN(MAX_LEN)
) u_lvp_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .longest  (longest),
  .overflow (overflow)
);

/* bench/testbench.sv */
// self-checking testbench for the longest valid parentheses block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lvp_pkg::*;

  localparam int MAX_LEN = 65535;
  localparam int RANDOM_BYTES = 1900;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    item_t word;
    int    gap;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  symbol = 8'd0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] longest;
  logic        overflow;

  pending_t    pending_bytes[$];
  result_t     expected_lengths[$];
  bit          failed = 1'b0;
  int unsigned cycle_count = 0;

  // predictor state
  int unsigned position_stack[MAX_LEN];
  int unsigned top_pos;
  int unsigned stack_size;
  int unsigned byte_pos;
  int unsigned best_run;
  bit          too_long;

  // driver and receiver scratch
  bit          holding;
  pending_t    next_word;
  int          gap_count = 0;
  int          stall_count = 0;
  bit          rx_calm = 1'b0;
  result_t     want;

  longest_valid_paren_length #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .symbol(symbol),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .longest(longest),
    .overflow(overflow)
  );

  always #10 clk = ~clk;

  function automatic void clear_tracker();
    top_pos = 0;
    stack_size = 1;
    byte_pos = 0;
    best_run = 0;
    too_long = 1'b0;
  endfunction

  function automatic void track_paren_byte(logic [7:0] sym, logic fin);
    int unsigned here;
    int unsigned slot;
    result_t res;
    if (byte_pos >= MAX_LEN) begin
      too_long = 1'b1;
    end else begin
      here = byte_pos + 1;
      if (sym == OPEN_BRACKET) begin
        slot = stack_size - 1;
        if (slot < MAX_LEN) position_stack[slot] = top_pos;
        top_pos = here;
        stack_size = stack_size + 1;
      end else begin
        stack_size = stack_size - 1;
        if (stack_size == 0) begin
          top_pos = here;
          stack_size = 1;
        end else begin
          slot = stack_size - 1;
          top_pos = (slot < MAX_LEN) ? position_stack[slot] : 0;
          if (here >= top_pos && here - top_pos > best_run) best_run = here - top_pos;
        end
      end
      byte_pos = here;
    end
    if (fin) begin
      res.longest = (best_run > LONGEST_MAX) ? LONGEST_W'(LONGEST_MAX) : LONGEST_W'(best_run);
      res.overflow = too_long;
      expected_lengths.push_back(res);
      clear_tracker();
    end
  endfunction

  task automatic push_byte(logic [7:0] sym, logic fin, int gap);
    pending_t p;
    p.word.symbol = sym;
    p.word.last = fin;
    p.gap = gap;
    pending_bytes.push_back(p);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++)
      push_byte(8'(s[i]), i == s.len() - 1, $urandom_range(0, 10));
  endtask

  function automatic logic [7:0] closing_byte();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd41;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_count <= 0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        track_paren_byte(symbol, last);
        holding = 1'b0;
      end
      if (!holding && pending_bytes.size() != 0) begin
        if (gap_count < pending_bytes[0].gap) begin
          gap_count <= gap_count + 1;
        end else begin
          next_word = pending_bytes.pop_front();
          symbol <= next_word.word.symbol;
          last <= next_word.word.last;
          gap_count <= 0;
          holding = 1'b1;
        end
      end
      in_valid <= holding;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        stall_count = rx_calm ? 0 : $urandom_range(0, 10);
      end else if (stall_count != 0) begin
        stall_count = stall_count - 1;
      end
      out_ready <= (stall_count == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_lengths.size() == 0) begin
        $error("unexpected word: longest %0d overflow %0d", longest, overflow);
        failed = 1'b1;
      end else begin
        want = expected_lengths.pop_front();
        if (longest !== want.longest) begin
          $error("longest: expected %0d, actual %0d", want.longest, longest);
          failed = 1'b1;
        end
        if (overflow !== want.overflow) begin
          $error("overflow: expected %0d, actual %0d", want.overflow, overflow);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int len;
    int open_count;
    int random_count;
    int gap;
    bit calm;
    bit walk;
    bit opens;
    logic [7:0] sym;

    clear_tracker();

    // directed strings
    push_text("()");
    push_text(")");
    push_text("(");
    push_text("(()))()");
    push_text(")(");
    push_text("()(()");
    push_byte(OPEN_BRACKET, 1'b0, 0);
    push_byte(8'h00, 1'b0, 3);
    push_byte(OPEN_BRACKET, 1'b0, 0);
    push_byte(8'hff, 1'b0, 10);
    push_byte(8'd39, 1'b1, 1);

    // random strings
    random_count = 0;
    while (random_count < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 4) == 0);
      walk = ($urandom_range(0, 4) != 0);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      open_count = 0;
      for (int i = 0; i < len; i++) begin
        if (walk) begin
          opens = (open_count == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) == 0);
          if (opens) begin
            sym = OPEN_BRACKET;
            open_count++;
          end else begin
            sym = closing_byte();
            if (open_count > 0) open_count--;
          end
        end else begin
          sym = ($urandom_range(0, 1) == 0) ? OPEN_BRACKET : 8'($urandom_range(0, 255));
        end
        gap = calm ? 0 : $urandom_range(0, 10);
        push_byte(sym, i == len - 1, gap);
      end
      random_count += len;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
    while (expected_lengths.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed && expected_lengths.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
